// ===== rtl/wrapping_char_canvas_draw_core_macros.svh =====
// Assertion macros used by the canvas draw core checker.
`ifndef WRAPPING_CHAR_CANVAS_DRAW_CORE_MACROS_SVH
`define WRAPPING_CHAR_CANVAS_DRAW_CORE_MACROS_SVH

// Same-cycle implication under reset.
`define WCCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define WCCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wccd_pkg.sv =====
// Shared types, constants and codes of the wrapping character canvas draw core.
`default_nettype none

package wccd_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int W_W         = 8;
    localparam int H_W         = 7;
    localparam int COORD_W     = 16;
    localparam int MAG_W       = 17;
    localparam int CHAR_W      = 8;
    localparam int OP_W        = 3;
    localparam int CNT_W       = 8;
    localparam int BASE_W      = 15;
    localparam int DIV_CNT_W   = 5;
    localparam int LANES       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [W_W-1:0] RST_WIDTH  = 8'd128;
    localparam logic [H_W-1:0] RST_HEIGHT = 7'd64;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET   = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd2;
    localparam logic [OP_W-1:0] OP_HLINE = 3'd3;
    localparam logic [OP_W-1:0] OP_VLINE = 3'd4;
    localparam logic [OP_W-1:0] OP_RECT  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        K_SEG,
        K_READ,
        K_FILL,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              last;
        logic              vert;
        logic [W_W-1:0]    cx;
        logic [H_W-1:0]    cy;
        logic [BASE_W-1:0] base;
        logic [CNT_W-1:0]  cnt;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_FIX,
        F_SUM,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RUN,
        B_RD,
        B_RDW,
        B_FIN
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/wrapping_char_canvas_draw_core.sv =====
// Top level of the wrapping character canvas draw core.
// Front end takes a new request only while idle and splits it into cell commands, four for rect:
// a bit-serial remainder unit over 17-bit magnitudes wraps the coordinates. The draw engine
// writes one cell per cycle while it runs a command, through a single RAM port.
// Reset is asynchronous: control and size registers (128 x 64) clear, the store does not.
`default_nettype none

module wrapping_char_canvas_draw_core #(
    parameter int MAX_WIDTH  = wccd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wccd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [wccd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wccd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [wccd_pkg::OP_W-1:0]           opcode,
    input  wire logic signed [wccd_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [wccd_pkg::COORD_W-1:0] pos_y,
    input  wire logic signed [wccd_pkg::COORD_W-1:0] span_length,
    input  wire logic signed [wccd_pkg::COORD_W-1:0] rect_height,
    input  wire logic [wccd_pkg::CHAR_W-1:0]         cell_char,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [wccd_pkg::CHAR_W-1:0]              read_char,
    output logic                                     was_read
);

    localparam int W_CAP_I = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
    localparam int H_CAP_I = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
    localparam logic [wccd_pkg::W_W-1:0] W_CAP = wccd_pkg::W_W'(W_CAP_I);
    localparam logic [wccd_pkg::H_W-1:0] H_CAP = wccd_pkg::H_W'(H_CAP_I);

    logic [wccd_pkg::W_W-1:0] canvas_width_reg, canvas_width_next;
    logic [wccd_pkg::H_W-1:0] canvas_height_reg, canvas_height_next;
    logic [wccd_pkg::W_W-1:0] eff_w;
    logic [wccd_pkg::H_W-1:0] eff_h;

    logic           push_valid, queue_full, queue_empty, pop;
    wccd_pkg::cmd_t push_cmd, pop_cmd;

    always_comb
    begin
        canvas_width_next  = canvas_width_reg;
        canvas_height_next = canvas_height_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wccd_pkg::REG_WIDTH:
                begin
                    canvas_width_next = cfg_data;
                end
                wccd_pkg::REG_HEIGHT:
                begin
                    canvas_height_next = cfg_data[wccd_pkg::H_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= wccd_pkg::RST_WIDTH;
            canvas_height_reg <= wccd_pkg::RST_HEIGHT;
        end
        else
        begin
            canvas_width_reg  <= canvas_width_next;
            canvas_height_reg <= canvas_height_next;
        end
    end

    // zero acts as one, oversize clamps to the store geometry
    always_comb
    begin
        if (canvas_width_reg == '0)
        begin
            eff_w = wccd_pkg::W_W'(1);
        end
        else if (canvas_width_reg > W_CAP)
        begin
            eff_w = W_CAP;
        end
        else
        begin
            eff_w = canvas_width_reg;
        end

        if (canvas_height_reg == '0)
        begin
            eff_h = wccd_pkg::H_W'(1);
        end
        else if (canvas_height_reg > H_CAP)
        begin
            eff_h = H_CAP;
        end
        else
        begin
            eff_h = canvas_height_reg;
        end
    end

    wccd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .span_length (span_length),
        .rect_height (rect_height),
        .cell_char   (cell_char),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd),
        .queue_full  (queue_full)
    );

    wccd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (queue_empty)
    );

    wccd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .queue_empty (queue_empty),
        .pop         (pop),
        .pop_cmd     (pop_cmd),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_char   (read_char),
        .was_read    (was_read)
    );

endmodule

`default_nettype wire

// ===== rtl/wccd_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module wccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                     wdata,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/wccd_front.sv =====
// Front end: accepts requests, wraps coordinates and splits them into cell commands.
`default_nettype none

module wccd_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [wccd_pkg::OP_W-1:0]            opcode,
    input  wire logic signed [wccd_pkg::COORD_W-1:0]  pos_x,
    input  wire logic signed [wccd_pkg::COORD_W-1:0]  pos_y,
    input  wire logic signed [wccd_pkg::COORD_W-1:0]  span_length,
    input  wire logic signed [wccd_pkg::COORD_W-1:0]  rect_height,
    input  wire logic [wccd_pkg::CHAR_W-1:0]          cell_char,
    input  wire logic [wccd_pkg::W_W-1:0]             eff_w,
    input  wire logic [wccd_pkg::H_W-1:0]             eff_h,
    output logic                                      push_valid,
    output wccd_pkg::cmd_t                            push_cmd,
    input  wire logic                                 queue_full
);

    localparam int MAG_W = wccd_pkg::MAG_W;
    localparam int W_W   = wccd_pkg::W_W;
    localparam int H_W   = wccd_pkg::H_W;
    localparam int CNT_W = wccd_pkg::CNT_W;
    localparam int LANES = wccd_pkg::LANES;
    localparam logic [wccd_pkg::DIV_CNT_W-1:0] DIV_LAST = wccd_pkg::DIV_CNT_W'(MAG_W - 1);

    // lanes: 0 x mod w, 1 y mod h, 2 (len-1) mod w, 3 (rh-1) mod h
    wccd_pkg::front_state_t state_reg, state_next;
    logic [wccd_pkg::OP_W-1:0]      op_reg, op_next;
    logic [wccd_pkg::CHAR_W-1:0]    ch_reg, ch_next;
    logic [wccd_pkg::COORD_W-1:0]   len_reg, len_next;
    logic [wccd_pkg::COORD_W-1:0]   rh_reg, rh_next;
    logic [MAG_W-1:0]               mag_reg [LANES];
    logic [MAG_W-1:0]               mag_next [LANES];
    logic                           neg_reg [LANES];
    logic                           neg_next [LANES];
    logic [W_W-1:0]                 rem_reg [LANES];
    logic [W_W-1:0]                 rem_next [LANES];
    logic [wccd_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [W_W-1:0]                 x2_reg, x2_next;
    logic [H_W-1:0]                 y2_reg, y2_next;
    logic [wccd_pkg::BASE_W-1:0]    base0_reg, base0_next;
    logic [wccd_pkg::BASE_W-1:0]    base1_reg, base1_next;
    logic [1:0]                     seg_reg, seg_next;

    logic [W_W-1:0]   mod_l [LANES];
    logic [MAG_W-1:0] v_in [LANES];
    logic [W_W:0]     shifted [LANES];
    logic [W_W:0]     x2_sum;
    logic [H_W:0]     y2_sum;
    logic [MAG_W-1:0] len_s, a_s, rh_s, b_s;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [MAG_W-1:0] v,
                                                     input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] r;
        if (v[MAG_W-1] || v == '0)
        begin
            r = '0;
        end
        else if (v[MAG_W-2:0] > (MAG_W-1)'(cap))
        begin
            r = cap;
        end
        else
        begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

    assign mod_l[0] = eff_w;
    assign mod_l[1] = {1'b0, eff_h};
    assign mod_l[2] = eff_w;
    assign mod_l[3] = {1'b0, eff_h};

    assign v_in[0] = {pos_x[15], pos_x};
    assign v_in[1] = {pos_y[15], pos_y};
    assign v_in[2] = {span_length[15], span_length} - 17'd1;
    assign v_in[3] = {rect_height[15], rect_height} - 17'd1;

    assign len_s = {len_reg[15], len_reg};
    assign a_s   = len_s - 17'd1;
    assign rh_s  = {rh_reg[15], rh_reg};
    assign b_s   = rh_s - 17'd1;

    assign in_stall = (state_reg != wccd_pkg::F_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wccd_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wccd_pkg::F_DIV;
                end
            end
            wccd_pkg::F_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = wccd_pkg::F_FIX;
                end
            end
            wccd_pkg::F_FIX:
            begin
                state_next = wccd_pkg::F_SUM;
            end
            wccd_pkg::F_SUM:
            begin
                state_next = wccd_pkg::F_MUL;
            end
            wccd_pkg::F_MUL:
            begin
                state_next = wccd_pkg::F_PUSH;
            end
            wccd_pkg::F_PUSH:
            begin
                if (!queue_full && push_cmd.last)
                begin
                    state_next = wccd_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = wccd_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        ch_next      = ch_reg;
        len_next     = len_reg;
        rh_next      = rh_reg;
        div_cnt_next = div_cnt_reg;
        x2_next      = x2_reg;
        y2_next      = y2_reg;
        base0_next   = base0_reg;
        base1_next   = base1_reg;
        seg_next     = seg_reg;
        x2_sum       = {1'b0, rem_reg[0]} + {1'b0, rem_reg[2]};
        y2_sum       = {1'b0, rem_reg[1][H_W-1:0]} + {1'b0, rem_reg[3][H_W-1:0]};
        for (int i = 0; i < LANES; i++)
        begin
            mag_next[i] = mag_reg[i];
            neg_next[i] = neg_reg[i];
            rem_next[i] = rem_reg[i];
            shifted[i]  = {rem_reg[i], mag_reg[i][MAG_W-1]};
        end

        push_valid    = (state_reg == wccd_pkg::F_PUSH);
        push_cmd.kind = wccd_pkg::K_SEG;
        push_cmd.last = 1'b1;
        push_cmd.vert = 1'b0;
        push_cmd.cx   = rem_reg[0];
        push_cmd.cy   = rem_reg[1][H_W-1:0];
        push_cmd.base = base0_reg;
        push_cmd.cnt  = '0;
        push_cmd.ch   = ch_reg;

        unique case (op_reg)
            wccd_pkg::OP_SET:
            begin
                push_cmd.cnt = CNT_W'(1);
            end
            wccd_pkg::OP_GET:
            begin
                push_cmd.kind = wccd_pkg::K_READ;
            end
            wccd_pkg::OP_FILL:
            begin
                push_cmd.kind = wccd_pkg::K_FILL;
            end
            wccd_pkg::OP_HLINE:
            begin
                push_cmd.cnt = clamp_count(len_s, eff_w);
            end
            wccd_pkg::OP_VLINE:
            begin
                push_cmd.vert = 1'b1;
                push_cmd.cnt  = clamp_count(len_s, {1'b0, eff_h});
            end
            wccd_pkg::OP_RECT:
            begin
                push_cmd.last = (seg_reg == 2'd3);
                case (seg_reg)
                    2'd0:
                    begin
                        push_cmd.cnt = clamp_count(a_s, eff_w);
                    end
                    2'd1:
                    begin
                        push_cmd.cy   = y2_reg;
                        push_cmd.base = base1_reg;
                        push_cmd.cnt  = clamp_count(a_s, eff_w);
                    end
                    2'd2:
                    begin
                        push_cmd.vert = 1'b1;
                        push_cmd.cnt  = clamp_count(b_s, {1'b0, eff_h});
                    end
                    default:
                    begin
                        push_cmd.vert = 1'b1;
                        push_cmd.cx   = x2_reg;
                        push_cmd.cnt  = clamp_count(rh_s, {1'b0, eff_h});
                    end
                endcase
            end
            default:
            begin
                push_cmd.kind = wccd_pkg::K_NOP;
            end
        endcase

        unique case (state_reg)
            wccd_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = opcode;
                    ch_next      = cell_char;
                    len_next     = span_length;
                    rh_next      = rect_height;
                    div_cnt_next = '0;
                    seg_next     = '0;
                    for (int i = 0; i < LANES; i++)
                    begin
                        neg_next[i] = v_in[i][MAG_W-1];
                        mag_next[i] = v_in[i][MAG_W-1] ? (~v_in[i] + 17'd1) : v_in[i];
                        rem_next[i] = '0;
                    end
                end
            end
            wccd_pkg::F_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                for (int i = 0; i < LANES; i++)
                begin
                    mag_next[i] = {mag_reg[i][MAG_W-2:0], 1'b0};
                    if (shifted[i] >= {1'b0, mod_l[i]})
                    begin
                        rem_next[i] = W_W'(shifted[i] - {1'b0, mod_l[i]});
                    end
                    else
                    begin
                        rem_next[i] = shifted[i][W_W-1:0];
                    end
                end
            end
            wccd_pkg::F_FIX:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (neg_reg[i] && rem_reg[i] != '0)
                    begin
                        rem_next[i] = mod_l[i] - rem_reg[i];
                    end
                end
            end
            wccd_pkg::F_SUM:
            begin
                if (x2_sum >= {1'b0, eff_w})
                begin
                    x2_next = W_W'(x2_sum - {1'b0, eff_w});
                end
                else
                begin
                    x2_next = x2_sum[W_W-1:0];
                end
                if (y2_sum >= {1'b0, eff_h})
                begin
                    y2_next = H_W'(y2_sum - {1'b0, eff_h});
                end
                else
                begin
                    y2_next = y2_sum[H_W-1:0];
                end
            end
            wccd_pkg::F_MUL:
            begin
                base0_next = wccd_pkg::BASE_W'(rem_reg[1][H_W-1:0])
                           * wccd_pkg::BASE_W'(eff_w);
                base1_next = wccd_pkg::BASE_W'(y2_reg) * wccd_pkg::BASE_W'(eff_w);
            end
            wccd_pkg::F_PUSH:
            begin
                if (!queue_full)
                begin
                    seg_next = seg_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wccd_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ch_reg      <= ch_next;
        len_reg     <= len_next;
        rh_reg      <= rh_next;
        div_cnt_reg <= div_cnt_next;
        x2_reg      <= x2_next;
        y2_reg      <= y2_next;
        base0_reg   <= base0_next;
        base1_reg   <= base1_next;
        seg_reg     <= seg_next;
        for (int i = 0; i < LANES; i++)
        begin
            mag_reg[i] <= mag_next[i];
            neg_reg[i] <= neg_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wccd_queue.sv =====
// Short command queue between the front end and the draw engine.
`default_nettype none

module wccd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wccd_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output wccd_pkg::cmd_t      pop_cmd,
    output logic                empty
);

    localparam int DEPTH = wccd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wccd_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wccd_back.sv =====
// Draw engine: walks cell commands over the canvas store and returns results.
`default_nettype none

module wccd_back #(
    parameter int MAX_WIDTH  = wccd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wccd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [wccd_pkg::W_W-1:0]     eff_w,
    input  wire logic [wccd_pkg::H_W-1:0]     eff_h,
    input  wire logic                         queue_empty,
    output logic                              pop,
    input  wccd_pkg::cmd_t                    pop_cmd,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [wccd_pkg::CHAR_W-1:0]       read_char,
    output logic                              was_read
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_W    = wccd_pkg::W_W;
    localparam int H_W    = wccd_pkg::H_W;
    localparam int BASE_W = wccd_pkg::BASE_W;
    localparam int CHAR_W = wccd_pkg::CHAR_W;

    wccd_pkg::back_state_t state_reg, state_next;
    wccd_pkg::cmd_kind_t   kind_reg, kind_next;
    logic                  last_reg, last_next;
    logic                  vert_reg, vert_next;
    logic [W_W-1:0]        cx_reg, cx_next;
    logic [H_W-1:0]        cy_reg, cy_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [wccd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [CHAR_W-1:0]     ch_reg, ch_next;
    logic [CHAR_W-1:0]     rd_reg, rd_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     read_char_reg, read_char_next;
    logic                  was_read_reg, was_read_next;

    logic [BASE_W-1:0]     cell_addr;
    logic [CHAR_W-1:0]     ram_rdata;
    logic                  ram_we;
    logic                  slot_free;
    logic                  x_end, y_end;

    assign cell_addr = base_reg + BASE_W'(cx_reg);
    assign ram_we    = (state_reg == wccd_pkg::B_RUN);
    assign slot_free = !out_valid_reg || !out_stall;
    assign x_end     = (cx_reg == eff_w - 1'b1);
    assign y_end     = (cy_reg == eff_h - 1'b1);
    assign out_valid = out_valid_reg;
    assign read_char = read_char_reg;
    assign was_read  = was_read_reg;

    wccd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ADDR_W'(cell_addr)),
        .wdata (ch_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wccd_pkg::B_IDLE:
            begin
                if (!queue_empty)
                begin
                    unique case (pop_cmd.kind)
                        wccd_pkg::K_SEG:
                        begin
                            state_next = (pop_cmd.cnt == '0) ? wccd_pkg::B_FIN
                                                             : wccd_pkg::B_RUN;
                        end
                        wccd_pkg::K_READ:
                        begin
                            state_next = wccd_pkg::B_RD;
                        end
                        wccd_pkg::K_FILL:
                        begin
                            state_next = wccd_pkg::B_RUN;
                        end
                        wccd_pkg::K_NOP:
                        begin
                            state_next = wccd_pkg::B_FIN;
                        end
                    endcase
                end
            end
            wccd_pkg::B_RUN:
            begin
                if (kind_reg == wccd_pkg::K_FILL)
                begin
                    if (x_end && y_end)
                    begin
                        state_next = wccd_pkg::B_FIN;
                    end
                end
                else if (cnt_reg == wccd_pkg::CNT_W'(1))
                begin
                    state_next = wccd_pkg::B_FIN;
                end
            end
            wccd_pkg::B_RD:
            begin
                state_next = wccd_pkg::B_RDW;
            end
            wccd_pkg::B_RDW:
            begin
                state_next = wccd_pkg::B_FIN;
            end
            wccd_pkg::B_FIN:
            begin
                if (!last_reg || slot_free)
                begin
                    state_next = wccd_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = wccd_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kind_next      = kind_reg;
        last_next      = last_reg;
        vert_next      = vert_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        rd_next        = rd_reg;
        read_char_next = read_char_reg;
        was_read_next  = was_read_reg;
        out_valid_next = out_valid_reg && out_stall;
        pop            = 1'b0;

        unique case (state_reg)
            wccd_pkg::B_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop       = 1'b1;
                    kind_next = pop_cmd.kind;
                    last_next = pop_cmd.last;
                    vert_next = pop_cmd.vert;
                    cx_next   = pop_cmd.cx;
                    cy_next   = pop_cmd.cy;
                    base_next = pop_cmd.base;
                    cnt_next  = pop_cmd.cnt;
                    ch_next   = pop_cmd.ch;
                    if (pop_cmd.kind == wccd_pkg::K_FILL)
                    begin
                        cx_next   = '0;
                        cy_next   = '0;
                        base_next = '0;
                    end
                end
            end
            wccd_pkg::B_RUN:
            begin
                if (kind_reg == wccd_pkg::K_FILL)
                begin
                    if (x_end)
                    begin
                        cx_next   = '0;
                        cy_next   = cy_reg + 1'b1;
                        base_next = base_reg + BASE_W'(eff_w);
                    end
                    else
                    begin
                        cx_next = cx_reg + 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (vert_reg)
                    begin
                        if (y_end)
                        begin
                            cy_next   = '0;
                            base_next = '0;
                        end
                        else
                        begin
                            cy_next   = cy_reg + 1'b1;
                            base_next = base_reg + BASE_W'(eff_w);
                        end
                    end
                    else
                    begin
                        cx_next = x_end ? '0 : cx_reg + 1'b1;
                    end
                end
            end
            wccd_pkg::B_RD:
            begin
            end
            wccd_pkg::B_RDW:
            begin
                rd_next = ram_rdata;
            end
            wccd_pkg::B_FIN:
            begin
                if (last_reg && slot_free)
                begin
                    out_valid_next = 1'b1;
                    was_read_next  = (kind_reg == wccd_pkg::K_READ);
                    read_char_next = (kind_reg == wccd_pkg::K_READ) ? rd_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wccd_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        last_reg      <= last_next;
        vert_reg      <= vert_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        base_reg      <= base_next;
        cnt_reg       <= cnt_next;
        ch_reg        <= ch_next;
        rd_reg        <= rd_next;
        read_char_reg <= read_char_next;
        was_read_reg  <= was_read_next;
    end

endmodule

`default_nettype wire

// ===== rtl/wccd_checker.sv =====
// Port-level checker for the canvas draw core, bound to the top level.
`default_nettype none

`include "wrapping_char_canvas_draw_core_macros.svh"

module wccd_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [wccd_pkg::CHAR_W-1:0]     read_char,
    input wire logic                            was_read
);

    // requests taken but not yet answered
    logic [3:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `WCCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_char) && $stable(was_read), "stalled result changed")
    `WCCD_ASSERT_IMP(a_zero_unless_read, clk, rst_n, out_valid && !was_read, read_char == '0, "nonzero char on non-get result")
    `WCCD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall, "front took a request while wrapping")
    `WCCD_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, pend_reg != 4'd0, "result without a pending request")

endmodule

bind wrapping_char_canvas_draw_core wccd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_char (read_char),
    .was_read  (was_read)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the wrapping character canvas draw core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODEL_COLS = wccd_pkg::DEF_MAX_WIDTH;
    localparam int MODEL_ROWS = wccd_pkg::DEF_MAX_HEIGHT;
    localparam logic [wccd_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [wccd_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct {
        logic [wccd_pkg::CHAR_W-1:0] rd;
        logic                        flag;
    } cell_reply_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [wccd_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [wccd_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [wccd_pkg::OP_W-1:0]           opcode = '0;
    logic signed [wccd_pkg::COORD_W-1:0] pos_x = '0;
    logic signed [wccd_pkg::COORD_W-1:0] pos_y = '0;
    logic signed [wccd_pkg::COORD_W-1:0] span_length = '0;
    logic signed [wccd_pkg::COORD_W-1:0] rect_height = '0;
    logic [wccd_pkg::CHAR_W-1:0]         cell_char = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [wccd_pkg::CHAR_W-1:0]         read_char;
    logic                                was_read;

    // canvas mirror and size registers
    logic [wccd_pkg::CHAR_W-1:0] canvas_model [0:MODEL_COLS*MODEL_ROWS-1];
    logic [wccd_pkg::W_W-1:0]    width_reg = wccd_pkg::RST_WIDTH;
    logic [wccd_pkg::H_W-1:0]    height_reg = wccd_pkg::RST_HEIGHT;
    cell_reply_t                 pending_replies [$];

    bit tx_gaps = 1'b0;
    bit rx_gaps = 1'b0;
    int rx_hold_cycles = 0;
    int mismatch_count = 0;
    int sent_count = 0;
    int get_count = 0;
    int line_count = 0;
    int rect_count = 0;
    int fill_count = 0;
    int size_count = 0;

    wrapping_char_canvas_draw_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .span_length (span_length),
        .rect_height (rect_height),
        .cell_char   (cell_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_char   (read_char),
        .was_read    (was_read)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("wrapping_char_canvas_draw_core test failed");
        $finish;
    end

    function automatic int cols_in_use();
        if (width_reg < 1)
            return 1;
        if (width_reg > MODEL_COLS)
            return MODEL_COLS;
        return width_reg;
    endfunction

    function automatic int rows_in_use();
        if (height_reg < 1)
            return 1;
        if (height_reg > MODEL_ROWS)
            return MODEL_ROWS;
        return height_reg;
    endfunction

    function automatic int wrap_coord(int v, int m);
        int r;
        r = v % m;
        if (r < 0)
            r += m;
        return r;
    endfunction

    // a line longer than the canvas only repeats its own writes
    function automatic void paint_run(int x, int y, int len, bit vertical,
                                      logic [wccd_pkg::CHAR_W-1:0] ch);
        int w;
        int h;
        int cx;
        int cy;
        int n;
        w = cols_in_use();
        h = rows_in_use();
        if (len <= 0)
            return;
        cx = wrap_coord(x, w);
        cy = wrap_coord(y, h);
        if (vertical)
            n = (len > h) ? h : len;
        else
            n = (len > w) ? w : len;
        for (int i = 0; i < n; i++)
        begin
            canvas_model[cy * w + cx] = ch;
            if (vertical)
            begin
                cy++;
                if (cy >= h)
                    cy = 0;
            end
            else
            begin
                cx++;
                if (cx >= w)
                    cx = 0;
            end
        end
    endfunction

    function automatic void apply_request(logic [wccd_pkg::OP_W-1:0] op, int x, int y,
                                          int len, int rh,
                                          logic [wccd_pkg::CHAR_W-1:0] ch);
        cell_reply_t want;
        int w;
        int h;
        w = cols_in_use();
        h = rows_in_use();
        want.rd = '0;
        want.flag = 1'b0;
        sent_count++;
        case (op)
            wccd_pkg::OP_SET:
                canvas_model[wrap_coord(y, h) * w + wrap_coord(x, w)] = ch;
            wccd_pkg::OP_GET:
            begin
                want.rd = canvas_model[wrap_coord(y, h) * w + wrap_coord(x, w)];
                want.flag = 1'b1;
                get_count++;
            end
            wccd_pkg::OP_FILL:
            begin
                for (int i = 0; i < w * h; i++)
                    canvas_model[i] = ch;
                fill_count++;
            end
            wccd_pkg::OP_HLINE:
            begin
                paint_run(x, y, len, 1'b0, ch);
                line_count++;
            end
            wccd_pkg::OP_VLINE:
            begin
                paint_run(x, y, len, 1'b1, ch);
                line_count++;
            end
            wccd_pkg::OP_RECT:
            begin
                paint_run(x, y, len - 1, 1'b0, ch);
                paint_run(x, y + rh - 1, len - 1, 1'b0, ch);
                paint_run(x, y, rh - 1, 1'b1, ch);
                paint_run(x + len - 1, y, rh, 1'b1, ch);
                rect_count++;
            end
            default:
                ;
        endcase
        pending_replies.push_back(want);
    endfunction

    function automatic void report_mismatch(string what, int want_v, int got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %0d, got %0d (at %0t)",
                     what, want_v, got_v, $realtime);
    endfunction

    always @(posedge clk)
    begin : reply_check
        cell_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("unexpected reply, read_char", -1, read_char);
            else
            begin
                want = pending_replies.pop_front();
                if (read_char !== want.rd)
                    report_mismatch("read_char", want.rd, read_char);
                if (was_read !== want.flag)
                    report_mismatch("was_read", want.flag, was_read);
            end
        end
    end

    // output side: random stall bursts, or one long hold when asked
    initial
    begin : reply_stall
        int n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(logic [wccd_pkg::OP_W-1:0] op,
                                logic signed [wccd_pkg::COORD_W-1:0] x,
                                logic signed [wccd_pkg::COORD_W-1:0] y,
                                logic signed [wccd_pkg::COORD_W-1:0] len,
                                logic signed [wccd_pkg::COORD_W-1:0] rh,
                                logic [wccd_pkg::CHAR_W-1:0] ch);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        pos_x       <= x;
        pos_y       <= y;
        span_length <= len;
        rect_height <= rh;
        cell_char   <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_request(op, x, y, len, rh, ch);
    endtask

    function automatic logic signed [wccd_pkg::COORD_W-1:0] pick_coord(int m);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(0, 3 * m) - m;
            6, 7: v = $urandom_range(0, 65535);
            8: v = $urandom_range(0, 1) ? 32767 : -32768;
            default: v = -$urandom_range(1, 2 * m);
        endcase
        return v[wccd_pkg::COORD_W-1:0];
    endfunction

    function automatic logic signed [wccd_pkg::COORD_W-1:0] pick_span(int cap);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(0, cap + 2);
            6: v = -$urandom_range(0, 40);
            7: v = $urandom_range(0, 65535);
            8: v = $urandom_range(0, 2);
            default: v = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        return v[wccd_pkg::COORD_W-1:0];
    endfunction

    task automatic send_random_request();
        int w;
        int h;
        int sel;
        logic [wccd_pkg::OP_W-1:0] op;
        w = cols_in_use();
        h = rows_in_use();
        sel = $urandom_range(0, 99);
        if (sel < 25)
            op = wccd_pkg::OP_SET;
        else if (sel < 50)
            op = wccd_pkg::OP_GET;
        else if (sel < 65)
            op = wccd_pkg::OP_HLINE;
        else if (sel < 80)
            op = wccd_pkg::OP_VLINE;
        else if (sel < 92)
            op = wccd_pkg::OP_RECT;
        else if (sel < 95)
            op = wccd_pkg::OP_FILL;
        else if (sel < 98)
            op = OP_UNDEF_LO;
        else
            op = OP_UNDEF_HI;
        send_request(op, pick_coord(w), pick_coord(h),
                     pick_span((op == wccd_pkg::OP_VLINE) ? h : w),
                     pick_span(h), 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_canvas(logic [wccd_pkg::CFG_DATA_W-1:0] w,
                              logic [wccd_pkg::CFG_DATA_W-1:0] h);
        wait_for_replies();
        cfg_wr_en <= 1'b1;
        cfg_index <= wccd_pkg::REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= wccd_pkg::REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        width_reg  = w;
        height_reg = h[wccd_pkg::H_W-1:0];
        size_count++;
    endtask

    // the opening fill at full size writes every cell, so no later read is of an unwritten cell
    task automatic test_reset_canvas_directed();
        send_request(wccd_pkg::OP_FILL, 16'sd3, -16'sd9, 16'sd0, 16'sd0, 8'h5A);
        send_request(wccd_pkg::OP_GET, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00);
        send_request(wccd_pkg::OP_SET, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 8'hFF);
        send_request(wccd_pkg::OP_SET, 16'sd32767, 16'sd32767, 16'sh7FFF, 16'sh7FFF, 8'h00);
        send_request(wccd_pkg::OP_GET, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 8'hFF);
        send_request(wccd_pkg::OP_GET, -16'sd32768, -16'sd32768, -16'sd1, -16'sd1, 8'h00);
        send_request(wccd_pkg::OP_HLINE, 16'sd120, 16'sd5, 16'sd16, 16'sd0, 8'h41);
        send_request(wccd_pkg::OP_GET, 16'sd3, 16'sd5, 16'sd0, 16'sd0, 8'h00);
        send_request(wccd_pkg::OP_HLINE, 16'sd10, 16'sd6, 16'sd0, 16'sd0, 8'h11);
        send_request(wccd_pkg::OP_HLINE, 16'sd10, 16'sd6, -16'sd32768, 16'sd0, 8'h12);
        send_request(wccd_pkg::OP_HLINE, 16'sd77, -16'sd1, 16'sd32767, 16'sd0, 8'h42);
        send_request(wccd_pkg::OP_VLINE, 16'sd7, 16'sd60, 16'sd10, 16'sd0, 8'h43);
        send_request(wccd_pkg::OP_VLINE, -16'sd300, 16'sd2, 16'sd32767, 16'sd0, 8'h44);
        send_request(wccd_pkg::OP_VLINE, 16'sd8, 16'sd8, -16'sd1, 16'sd0, 8'h13);
        send_request(wccd_pkg::OP_GET, 16'sd7, 16'sd1, 16'sd0, 16'sd0, 8'h00);
        send_request(wccd_pkg::OP_RECT, 16'sd100, 16'sd50, 16'sd40, 16'sd20, 8'h45);
        send_request(wccd_pkg::OP_GET, 16'sd139, 16'sd60, 16'sd0, 16'sd0, 8'h00);
        send_request(wccd_pkg::OP_RECT, 16'sd5, 16'sd5, 16'sd1, 16'sd1, 8'h46);
        send_request(wccd_pkg::OP_GET, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 8'h00);
        send_request(wccd_pkg::OP_RECT, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                     8'h47);
        send_request(wccd_pkg::OP_RECT, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 8'h48);
        send_request(OP_UNDEF_LO, 16'sh5555, -16'sd21846, 16'sh5555, -16'sd21846, 8'hAA);
        send_request(OP_UNDEF_HI, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 8'hFF);
        send_request(wccd_pkg::OP_GET, -16'sd32767, 16'sd100, 16'sd0, 16'sd0, 8'h00);
    endtask

    task automatic test_output_backpressure();
        tx_gaps = 1'b0;
        rx_hold_cycles = 400;
        repeat (24) send_random_request();
    endtask

    task automatic test_random_canvas(logic [wccd_pkg::CFG_DATA_W-1:0] w,
                                      logic [wccd_pkg::CFG_DATA_W-1:0] h,
                                      int n, bit gaps);
        set_canvas(w, h);
        tx_gaps = gaps;
        rx_gaps = gaps;
        repeat (n) send_random_request();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_canvas_directed();
        test_output_backpressure();
        test_random_canvas(8'd128, 8'd64, 140, 1'b1);
        test_random_canvas(8'd0, 8'd0, 60, 1'b1);
        test_random_canvas(8'd1, 8'd64, 90, 1'b1);
        test_random_canvas(8'd255, 8'd127, 110, 1'b1);
        test_random_canvas(8'd128, 8'd1, 90, 1'b0);
        test_random_canvas(8'd37, 8'd13, 110, 1'b1);
        test_random_canvas(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 110, 1'b1);
        test_random_canvas(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 60, 1'b1);
        test_random_canvas(8'd128, 8'd64, 100, 1'b0);
        wait_for_replies();
        repeat (64) @(posedge clk);
        $display("Ran %0d requests over %0d canvas sizes: %0d reads, %0d lines,",
                 sent_count, size_count, get_count, line_count);
        $display("%0d rects, %0d fills, with a long output hold-off; %0d mismatches seen.",
                 rect_count, fill_count, mismatch_count);
        if (mismatch_count == 0)
            $display("wrapping_char_canvas_draw_core test passed");
        else
            $display("wrapping_char_canvas_draw_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
